// File: rtl/rpnos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpnos_pkg
// types, constants and address helpers for the rpn operand stack
// ----------------------------------------------------------------------------
package rpnos_pkg;

   localparam int DEPTH = 16;
   localparam int WIDTH = 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   localparam logic [3:0] OP_PUSH     = 4'd0;
   localparam logic [3:0] OP_POP      = 4'd1;
   localparam logic [3:0] OP_PEEK     = 4'd2;
   localparam logic [3:0] OP_FLUSH    = 4'd3;
   localparam logic [3:0] OP_ROT_UP   = 4'd4;
   localparam logic [3:0] OP_ROT_DOWN = 4'd5;
   localparam logic [3:0] OP_EXCHANGE = 4'd6;
   localparam logic [3:0] OP_GET_TOP  = 4'd7;
   localparam logic [3:0] OP_GET_BOT  = 4'd8;
   localparam logic [3:0] OP_DEL_TOP  = 4'd9;
   localparam logic [3:0] OP_DEL_BOT  = 4'd10;

   typedef struct packed {
      logic [3:0]  op;
      logic [63:0] value;
      logic [7:0]  index;
   } req_type;

   typedef struct packed {
      logic [63:0] data;
      logic        found;
      logic [4:0]  count;
      logic        is_empty;
      logic        is_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ROT,
      ST_XR2,
      ST_XW1,
      ST_XW2,
      ST_DONE
   } state_type;

   // circular address: base plus offset, offset at most DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] base);
      logic [AW-1:0] r;
      if (base == '0) begin
         r = AW'(DEPTH - 1);
      end else begin
         r = base - AW'(1);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] eff_depth(input logic [4:0] cfg);
      logic [CW-1:0] d;
      if (cfg == 5'd0) begin
         d = CW'(1);
      end else if (9'(cfg) > 9'(DEPTH)) begin
         d = CW'(DEPTH);
      end else begin
         d = CW'(cfg);
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/rpn_operand_stack.sv
// path: push, flush, delete, an empty or out-of-range read and an unknown op go from
// idle to done; a read hit passes read, a rotate rot, an exchange xr2, xw1 and xw2
// flow: a new transfer is taken only once the result is registered and the state is
// back in idle, so requests do not overlap; a stalled result transfer holds this off
// reset: stack empty, depth register 16, result channel idle; ram not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_operand_stack
// bounded operand stack held as a circular buffer in one synchronous ram
// ----------------------------------------------------------------------------
module rpn_operand_stack (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire rpnos_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output rpnos_pkg::rsp_type   rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [4:0]           csr_data
);

   localparam int AW = rpnos_pkg::AW;
   localparam int CW = rpnos_pkg::CW;
   localparam int W  = rpnos_pkg::WIDTH;

   logic [W-1:0] mem [rpnos_pkg::DEPTH];

   rpnos_pkg::state_type state_ff, state_in;
   logic [AW-1:0] base_ff, base_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [4:0]    cfg_ff, cfg_in;
   logic [W-1:0]  data_ff, data_in;
   logic          found_ff, found_in;
   logic [AW-1:0] addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [W-1:0]  tmp_ff, tmp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rpnos_pkg::rsp_type rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [W-1:0]  mem_wdata, rdata_ff;

   logic [CW-1:0] depth, new_depth;
   logic          req_xfer;
   logic          idx_ok;

   assign depth     = rpnos_pkg::eff_depth(cfg_ff);
   assign new_depth = rpnos_pkg::eff_depth(csr_data);
   assign req_stall = (state_ff != rpnos_pkg::ST_IDLE) | csr_valid;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = (state_ff == rpnos_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign idx_ok    = 9'(req_data.index) < 9'(fill_ff);

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      cfg_in       = cfg_ff;
      data_in      = data_ff;
      found_in     = found_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      tmp_in       = tmp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = addr_a_ff;
      mem_wdata    = rdata_ff;
      mem_raddr    = rpnos_pkg::wrap_add(base_ff, fill_ff - CW'(1));

      case (state_ff)
         rpnos_pkg::ST_IDLE: begin
            if (req_xfer) begin
               data_in  = '0;
               found_in = 1'b0;
               state_in = rpnos_pkg::ST_DONE;
               case (req_data.op)
                  rpnos_pkg::OP_PUSH: begin
                     mem_we    = 1'b1;
                     mem_waddr = rpnos_pkg::wrap_add(base_ff, fill_ff);
                     mem_wdata = req_data.value[W-1:0];
                     if (fill_ff >= depth) begin
                        base_in = rpnos_pkg::wrap_add(base_ff, CW'(1));
                        fill_in = depth;
                     end else begin
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  rpnos_pkg::OP_POP, rpnos_pkg::OP_PEEK: begin
                     if (fill_ff != '0) begin
                        state_in = rpnos_pkg::ST_READ;
                        if (req_data.op == rpnos_pkg::OP_POP) begin
                           fill_in = fill_ff - CW'(1);
                        end
                     end
                  end
                  rpnos_pkg::OP_FLUSH: begin
                     fill_in = '0;
                  end
                  rpnos_pkg::OP_ROT_UP: begin
                     if (fill_ff > CW'(1)) begin
                        addr_a_in = rpnos_pkg::wrap_dec(base_ff);
                        base_in   = rpnos_pkg::wrap_dec(base_ff);
                        state_in  = rpnos_pkg::ST_ROT;
                     end
                  end
                  rpnos_pkg::OP_ROT_DOWN: begin
                     if (fill_ff > CW'(1)) begin
                        mem_raddr = base_ff;
                        addr_a_in = rpnos_pkg::wrap_add(base_ff, fill_ff);
                        base_in   = rpnos_pkg::wrap_add(base_ff, CW'(1));
                        state_in  = rpnos_pkg::ST_ROT;
                     end
                  end
                  rpnos_pkg::OP_EXCHANGE: begin
                     if (fill_ff > CW'(1)) begin
                        addr_a_in = rpnos_pkg::wrap_add(base_ff, fill_ff - CW'(1));
                        addr_b_in = rpnos_pkg::wrap_add(base_ff, fill_ff - CW'(2));
                        state_in  = rpnos_pkg::ST_XR2;
                     end
                  end
                  rpnos_pkg::OP_GET_TOP: begin
                     mem_raddr = rpnos_pkg::wrap_add(base_ff,
                                    fill_ff - CW'(1) - CW'(req_data.index));
                     if (idx_ok) begin
                        state_in = rpnos_pkg::ST_READ;
                     end
                  end
                  rpnos_pkg::OP_GET_BOT: begin
                     mem_raddr = rpnos_pkg::wrap_add(base_ff, CW'(req_data.index));
                     if (idx_ok) begin
                        state_in = rpnos_pkg::ST_READ;
                     end
                  end
                  rpnos_pkg::OP_DEL_TOP: begin
                     fill_in = idx_ok ? fill_ff - CW'(req_data.index) : '0;
                  end
                  rpnos_pkg::OP_DEL_BOT: begin
                     if (idx_ok) begin
                        base_in = rpnos_pkg::wrap_add(base_ff, CW'(req_data.index));
                        fill_in = fill_ff - CW'(req_data.index);
                     end else begin
                        fill_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rpnos_pkg::ST_READ: begin
            data_in  = rdata_ff;
            found_in = 1'b1;
            state_in = rpnos_pkg::ST_DONE;
         end
         rpnos_pkg::ST_ROT: begin
            mem_we    = 1'b1;
            mem_waddr = addr_a_ff;
            mem_wdata = rdata_ff;
            state_in  = rpnos_pkg::ST_DONE;
         end
         rpnos_pkg::ST_XR2: begin
            tmp_in    = rdata_ff;
            mem_raddr = addr_b_ff;
            state_in  = rpnos_pkg::ST_XW1;
         end
         rpnos_pkg::ST_XW1: begin
            mem_we    = 1'b1;
            mem_waddr = addr_a_ff;
            mem_wdata = rdata_ff;
            state_in  = rpnos_pkg::ST_XW2;
         end
         rpnos_pkg::ST_XW2: begin
            mem_we    = 1'b1;
            mem_waddr = addr_b_ff;
            mem_wdata = tmp_ff;
            state_in  = rpnos_pkg::ST_DONE;
         end
         rpnos_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.data     = 64'(data_ff);
               rsp_in.found    = found_ff;
               rsp_in.count    = 5'(fill_ff);
               rsp_in.is_empty = (fill_ff == '0);
               rsp_in.is_full  = (fill_ff == depth);
               rsp_valid_in    = 1'b1;
               state_in        = rpnos_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rpnos_pkg::ST_IDLE;
         end
      endcase

      // depth write, taken only while idle
      if (csr_valid && csr_ready) begin
         cfg_in = csr_data;
         if (fill_ff > new_depth) begin
            fill_in = new_depth;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpnos_pkg::ST_IDLE;
         base_ff      <= '0;
         fill_ff      <= '0;
         cfg_ff       <= 5'(rpnos_pkg::DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      found_ff  <= found_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      tmp_ff    <= tmp_in;
      rsp_ff    <= rsp_in;
   end

   // stack ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(rpnos_pkg::DEPTH))
      else $error("fill above built depth");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != rpnos_pkg::ST_IDLE)
      else $error("transfer in did not start work");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.is_empty == (rsp_ff.count == 5'd0)))
      else $error("empty flag disagrees with count");
`endif

endmodule
`default_nettype wire

// File: dv/tb_rpn_operand_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_operand_stack
// drives push, pop, peek, flush, read, rotate, exchange, delete and unknown-op requests into the operand stack
// under random bursts, gaps and result stalls, including one long receiver
// hold-off; a scoreboard keeps its own copy of the stack and depth register
// and compares every result field against its prediction, in order
// ----------------------------------------------------------------------------
module tb_rpn_operand_stack;

   localparam int CYCLE_LIMIT = 600000;

   class stack_scoreboard;
      logic [63:0] slots [16];
      int          fill;
      int          depth;
      rpnos_pkg::rsp_type pending_rsp [$];
      int          errors;

      function new();
         fill = 0;
         depth = 16;
         errors = 0;
      endfunction

      task report(input string what, input logic [63:0] got, input logic [63:0] want);
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      function void set_depth(input logic [4:0] v);
         depth = (v == 0) ? 1 : (v > 16) ? 16 : int'(v);
         if (fill > depth) begin
            fill = depth;
         end
      endfunction

      function void note_request(input rpnos_pkg::req_type rq);
         rpnos_pkg::rsp_type r;
         logic [63:0] t;
         int          n;
         n = int'(rq.index);
         r = '0;
         case (rq.op)
            rpnos_pkg::OP_PUSH: begin
               if (fill >= depth) begin
                  for (int i = 0; i < depth - 1; i++) slots[i] = slots[i+1];
                  slots[depth-1] = rq.value;
                  fill = depth;
               end else begin
                  slots[fill] = rq.value;
                  fill++;
               end
            end
            rpnos_pkg::OP_POP, rpnos_pkg::OP_PEEK: begin
               if (fill > 0) begin
                  r.data = slots[fill-1];
                  r.found = 1'b1;
                  if (rq.op == rpnos_pkg::OP_POP) fill--;
               end
            end
            rpnos_pkg::OP_FLUSH: fill = 0;
            rpnos_pkg::OP_ROT_UP: begin
               if (fill > 1) begin
                  t = slots[fill-1];
                  for (int i = fill - 1; i > 0; i--) slots[i] = slots[i-1];
                  slots[0] = t;
               end
            end
            rpnos_pkg::OP_ROT_DOWN: begin
               if (fill > 1) begin
                  t = slots[0];
                  for (int i = 0; i < fill - 1; i++) slots[i] = slots[i+1];
                  slots[fill-1] = t;
               end
            end
            rpnos_pkg::OP_EXCHANGE: begin
               if (fill > 1) begin
                  t = slots[fill-1];
                  slots[fill-1] = slots[fill-2];
                  slots[fill-2] = t;
               end
            end
            rpnos_pkg::OP_GET_TOP: begin
               if (n < fill) begin
                  r.data = slots[fill-1-n];
                  r.found = 1'b1;
               end
            end
            rpnos_pkg::OP_GET_BOT: begin
               if (n < fill) begin
                  r.data = slots[n];
                  r.found = 1'b1;
               end
            end
            rpnos_pkg::OP_DEL_TOP: fill = (n >= fill) ? 0 : fill - n;
            rpnos_pkg::OP_DEL_BOT: begin
               if (n >= fill) begin
                  fill = 0;
               end else begin
                  for (int i = 0; i < fill - n; i++) slots[i] = slots[i+n];
                  fill -= n;
               end
            end
            default: ;
         endcase
         r.count = 5'(fill);
         r.is_empty = (fill == 0);
         r.is_full = (fill == depth);
         pending_rsp.push_back(r);
      endfunction

      task check_result(input rpnos_pkg::rsp_type got);
         rpnos_pkg::rsp_type w;
         if (pending_rsp.size() == 0) begin
            report("unexpected transfer", 64'(got), 0);
         end else begin
            w = pending_rsp.pop_front();
            if (got.data !== w.data) report("data", got.data, w.data);
            if (got.found !== w.found) report("found", 64'(got.found), 64'(w.found));
            if (got.count !== w.count) report("count", 64'(got.count), 64'(w.count));
            if (got.is_empty !== w.is_empty)
               report("is_empty", 64'(got.is_empty), 64'(w.is_empty));
            if (got.is_full !== w.is_full)
               report("is_full", 64'(got.is_full), 64'(w.is_full));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   rpnos_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rpnos_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [4:0] csr_data = '0;

   stack_scoreboard sb = new();
   int  cycles = 0;
   int  burst_left = 0;
   bit  long_hold = 0;

   rpn_operand_stack u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_rpn_operand_stack: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 150);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= (cycles % 5 < 2);
            default: rsp_stall <= ($urandom_range(0, 99) < 70);
         endcase
      end
   end

   task send(input rpnos_pkg::req_type rq);
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      sb.note_request(rq);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task send_op(input logic [3:0] op, input logic [63:0] v, input logic [7:0] idx);
      rpnos_pkg::req_type rq;
      rq.op = op;
      rq.value = v;
      rq.index = idx;
      send(rq);
   endtask

   task write_depth(input logic [4:0] v);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_depth(v);
   endtask

   task random_item();
      rpnos_pkg::req_type rq;
      int      r;
      r = $urandom_range(0, 99);
      rq.value = {$urandom(), $urandom()};
      if (r < 38) begin
         rq.op = rpnos_pkg::OP_PUSH;
      end else if (r < 40) begin
         rq.op = 4'($urandom_range(11, 15));
      end else begin
         rq.op = 4'($urandom_range(1, 10));
      end
      if ($urandom_range(0, 9) == 0) begin
         rq.index = 8'($urandom());
      end else begin
         rq.index = 8'($urandom_range(0, sb.fill + 1));
      end
      send(rq);
   endtask

   initial begin
      logic [4:0] depths [10];
      depths = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd8, 5'd2, 5'd15, 5'd16};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_op(rpnos_pkg::OP_POP, '1, 8'd0);
      send_op(rpnos_pkg::OP_PEEK, 0, 8'd0);
      send_op(rpnos_pkg::OP_ROT_UP, 0, 8'd0);
      send_op(rpnos_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
      send_op(rpnos_pkg::OP_EXCHANGE, 0, 8'd0);
      send_op(rpnos_pkg::OP_ROT_DOWN, 0, 8'd0);
      send_op(rpnos_pkg::OP_PUSH, 64'h0, 8'hFF);
      send_op(rpnos_pkg::OP_PUSH, 64'h1234_5678_9ABC_DEF0, 8'd0);
      send_op(rpnos_pkg::OP_PUSH, 64'hA5A5_5A5A_0F0F_F0F0, 8'd0);
      send_op(rpnos_pkg::OP_ROT_UP, 0, 8'd0);
      send_op(rpnos_pkg::OP_ROT_DOWN, 0, 8'd0);
      send_op(rpnos_pkg::OP_EXCHANGE, 0, 8'd0);
      send_op(rpnos_pkg::OP_GET_TOP, 0, 8'd0);
      send_op(rpnos_pkg::OP_GET_TOP, 0, 8'd3);
      send_op(rpnos_pkg::OP_GET_BOT, 0, 8'd255);
      send_op(rpnos_pkg::OP_GET_BOT, 0, 8'd1);
      send_op(rpnos_pkg::OP_PEEK, 0, 8'd0);
      send_op(4'd11, '1, 8'hFF);
      send_op(4'd15, '1, 8'hFF);
      send_op(rpnos_pkg::OP_DEL_BOT, 0, 8'd1);
      send_op(rpnos_pkg::OP_DEL_TOP, 0, 8'd0);
      send_op(rpnos_pkg::OP_DEL_TOP, 0, 8'd255);
      send_op(rpnos_pkg::OP_PUSH, 64'h55, 8'd0);
      send_op(rpnos_pkg::OP_DEL_BOT, 0, 8'd200);
      send_op(rpnos_pkg::OP_FLUSH, 0, 8'd0);

      // random phases across depth settings
      for (int p = 0; p < 10; p++) begin
         write_depth(depths[p]);
         if (p == 4) long_hold = 1;
         repeat (183) random_item();
      end

      req_valid <= 1'b0;
      while (sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_rpn_operand_stack: PASS");
      end else begin
         $display("tb_rpn_operand_stack: FAIL");
      end
      $finish;
   end

endmodule
